[sv/utf8d_pkg.sv]
// shared types and codes of the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 3;
  localparam int unsigned PendW   = 2;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_STRAY    = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_LEAD = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_CONT = 3'd3;
  localparam logic [StatusW-1:0] ST_TRUNC    = 3'd4;

  localparam logic STRICT_RESET = 1'b1;

  // register index of strict_check
  localparam logic REG_STRICT = 1'b0;

  typedef struct packed {
    logic [PendW-1:0]  pending_count;
    logic [CpW-1:0]    partial_value;
    logic [CountW-1:0] bytes_seen;
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [CpW-1:0]     code_point;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  byte_count;
    logic               end_of_text;
  } result_t;

endpackage

[sv/utf8d_step.sv]
// one-byte decode step: next sequence state and optional result
module utf8d_step (
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              strict_check,
  input  utf8d_pkg::state_t st,
  output utf8d_pkg::state_t st_nxt,
  output utf8d_pkg::result_t res
);

  logic                          err;
  logic [utf8d_pkg::StatusW-1:0] err_status;
  logic [utf8d_pkg::CountW-1:0]  cnt;
  logic [utf8d_pkg::CpW-1:0]     cont_bits;
  logic [utf8d_pkg::CpW-1:0]     merged;
  logic [utf8d_pkg::PendW-1:0]   pend_dec;

  always_comb begin
    err        = 1'b0;
    err_status = utf8d_pkg::ST_OK;
    st_nxt     = st;
    res        = '0;
    res.end_of_text = last_byte;
    cnt        = st.bytes_seen + 3'd1;
    pend_dec   = st.pending_count - 2'd1;
    // continuation payload placed by how many bytes are still due
    case (st.pending_count)
      2'd2:    cont_bits = {9'd0, data_byte[5:0], 6'd0};
      2'd3:    cont_bits = {3'd0, data_byte[5:0], 12'd0};
      default: cont_bits = {15'd0, data_byte[5:0]};
    endcase
    merged = st.partial_value | cont_bits;

    if (st.pending_count == 2'd0) begin
      cnt = 3'd1;
      if (!data_byte[7]) begin
        res.valid      = 1'b1;
        res.code_point = {13'd0, data_byte};
        res.status     = utf8d_pkg::ST_OK;
        res.byte_count = 3'd1;
      end else if (!data_byte[6]) begin
        err        = 1'b1;
        err_status = utf8d_pkg::ST_STRAY;
      end else if (data_byte[3] && data_byte[4] && data_byte[5] && strict_check) begin
        err        = 1'b1;
        err_status = utf8d_pkg::ST_BAD_LEAD;
      end else begin
        if (!data_byte[5]) begin
          st_nxt.partial_value = {10'd0, data_byte[4:0], 6'd0};
          st_nxt.pending_count = 2'd1;
        end else if (!data_byte[4]) begin
          st_nxt.partial_value = {5'd0, data_byte[3:0], 12'd0};
          st_nxt.pending_count = 2'd2;
        end else begin
          st_nxt.partial_value = {data_byte[2:0], 18'd0};
          st_nxt.pending_count = 2'd3;
        end
        st_nxt.bytes_seen = 3'd1;
        if (last_byte) begin
          err        = 1'b1;
          err_status = utf8d_pkg::ST_TRUNC;
        end
      end
    end else begin
      if (strict_check && (data_byte[7:6] != 2'b10)) begin
        err        = 1'b1;
        err_status = utf8d_pkg::ST_BAD_CONT;
      end else if (pend_dec == 2'd0) begin
        res.valid      = 1'b1;
        res.code_point = merged;
        res.status     = utf8d_pkg::ST_OK;
        res.byte_count = cnt;
        st_nxt         = '0;
      end else begin
        st_nxt.partial_value = merged;
        st_nxt.pending_count = pend_dec;
        st_nxt.bytes_seen    = cnt;
        if (last_byte) begin
          err        = 1'b1;
          err_status = utf8d_pkg::ST_TRUNC;
        end
      end
    end

    // any failure drops the partial sequence
    if (err) begin
      st_nxt         = '0;
      res.valid      = 1'b1;
      res.code_point = '0;
      res.status     = err_status;
      res.byte_count = cnt;
    end
  end

endmodule

[sv/utf8_stream_decoder_core.sv]
// top level of the utf-8 stream decoder: byte channel in, code point channel out
//
// Decodes utf-8 text one byte per cycle while in_ready is high. Each accepted
// byte updates a small sequence state (continuation bytes still due, gathered
// code point bits, bytes taken) and may produce one result: a 21-bit code
// point with status ok, or an error status (stray continuation, bad 11111xxx
// lead, bad continuation, truncated text) that drops the open sequence. Results
// land in one output register in the cycle after the transfer; the input is ready
// whenever that register is empty or being taken, so with out_ready held high
// the block sustains one byte per cycle, limited only by the single
// state-update path between the state registers. in_last_byte marks the end
// of the text and is echoed as out_end_of_text; an unfinished sequence at that
// byte reports truncation. Overlong forms and surrogates are passed through.
// Register strict_check (address 0, reset 1) enables the bad-lead and
// bad-continuation checks; write it only while the block is idle.
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic [2:0]  out_status,
  output logic [2:0]  out_byte_count,
  output logic        out_end_of_text,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic strict_r;
  logic strict_nxt;
  logic cfg_wr;

  // sequence state and result register
  utf8d_pkg::state_t  st_r;
  utf8d_pkg::state_t  st_nxt;
  utf8d_pkg::result_t step_res;
  utf8d_pkg::result_t res_r;
  utf8d_pkg::result_t res_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               in_xfer;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register read mux, only strict_check is mapped
  always_comb begin
    prdata = '0;
    if (paddr[2] == utf8d_pkg::REG_STRICT) begin
      prdata[0] = strict_r;
    end
  end

  always_comb begin
    strict_nxt = strict_r;
    if (cfg_wr && (paddr[2] == utf8d_pkg::REG_STRICT)) begin
      strict_nxt = pwdata[0];
    end
  end

  // the output register frees when its result transfers out
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  utf8d_step u_step (
    .data_byte    (in_data_byte),
    .last_byte    (in_last_byte),
    .strict_check (strict_r),
    .st           (st_r),
    .st_nxt       (st_nxt),
    .res          (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (in_xfer) begin
      // a byte that completes nothing leaves the register empty
      out_valid_nxt = step_res.valid;
      res_nxt       = step_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r    <= utf8d_pkg::STRICT_RESET;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      strict_r    <= strict_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = res_r.code_point;
  assign out_status      = res_r.status;
  assign out_byte_count  = res_r.byte_count;
  assign out_end_of_text = res_r.end_of_text;

`ifndef ASSERT_OFF
  // errors never carry a code point
  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != utf8d_pkg::ST_OK) |-> res_r.code_point == '0)
    else $error("error result with nonzero code point");

  // idle state holds no leftover bits
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pending_count == 2'd0 |-> (st_r.bytes_seen == '0) && (st_r.partial_value == '0))
    else $error("idle decoder holds partial data");

  // the final byte of a text always closes the sequence
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_byte |=> st_r.pending_count == 2'd0 && out_valid_r)
    else $error("sequence left open after final byte");

  // every result consumed one to four bytes
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.byte_count != 3'd0) && (res_r.byte_count <= 3'd4))
    else $error("byte count out of range");
`endif

endmodule

[tb/utf8_check_pkg.sv]
`timescale 1ns / 1ps
// decode predictor and result checker for the utf-8 stream decoder testbench
package utf8_check_pkg;
  import utf8d_pkg::*;

  localparam int ContBits = 6;
  localparam int MaxPrints = 100;

  typedef struct packed {
    logic [CpW-1:0]     code_point;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  byte_count;
    logic               end_of_text;
  } cp_result_t;

  class utf8_scoreboard;
    logic              strict_on;
    logic [PendW-1:0]  cont_due;
    logic [CpW-1:0]    cp_bits;
    logic [CountW-1:0] seq_len;
    cp_result_t        decoded_q[$];
    int                errors;

    function new();
      strict_on = STRICT_RESET;
      errors = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      cont_due = '0;
      cp_bits = '0;
      seq_len = '0;
    endfunction

    function void queue_result(logic [CpW-1:0] cp, logic [StatusW-1:0] st,
                               logic [CountW-1:0] cnt, logic eot);
      cp_result_t r;
      r.code_point = cp;
      r.status = st;
      r.byte_count = cnt;
      r.end_of_text = eot;
      decoded_q.push_back(r);
    endfunction

    // error: open sequence is dropped
    function void reject(logic [StatusW-1:0] st, logic [CountW-1:0] cnt, logic eot);
      clear_sequence();
      queue_result('0, st, cnt, eot);
    endfunction

    function int outstanding();
      return decoded_q.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [CountW-1:0] cnt;
      logic [CpW-1:0]    done_cp;
      if (cont_due == '0) begin
        if (!b[7]) begin
          queue_result(CpW'(b), ST_OK, 3'd1, last);
          return;
        end
        if (!b[6]) begin
          reject(ST_STRAY, 3'd1, last);
          return;
        end
        if (!b[5]) begin
          cp_bits = CpW'(b[4:0]) << ContBits;
          cont_due = 2'd1;
        end else if (!b[4]) begin
          cp_bits = CpW'(b[3:0]) << (2 * ContBits);
          cont_due = 2'd2;
        end else if (b[3] && strict_on) begin
          reject(ST_BAD_LEAD, 3'd1, last);
          return;
        end else begin
          cp_bits = CpW'(b[2:0]) << (3 * ContBits);
          cont_due = 2'd3;
        end
        seq_len = 3'd1;
        if (last) reject(ST_TRUNC, 3'd1, 1'b1);
        return;
      end

      cnt = seq_len + 3'd1;
      if (strict_on && b[7:6] != 2'b10) begin
        reject(ST_BAD_CONT, cnt, last);
        return;
      end
      cp_bits = cp_bits | (CpW'(b[5:0]) << (ContBits * (int'(cont_due) - 1)));
      cont_due = cont_due - 2'd1;
      seq_len = cnt;
      if (cont_due == '0) begin
        done_cp = cp_bits;
        clear_sequence();
        queue_result(done_cp, ST_OK, cnt, last);
      end else if (last) begin
        reject(ST_TRUNC, cnt, 1'b1);
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= MaxPrints) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic [CpW-1:0] cp, logic [StatusW-1:0] st,
                      logic [CountW-1:0] cnt, logic eot);
      cp_result_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected result cp %h status %0d count %0d", cp, st, cnt));
        return;
      end
      want = decoded_q.pop_front();
      if (cp !== want.code_point)
        report($sformatf("code_point %h, want %h", cp, want.code_point));
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (cnt !== want.byte_count)
        report($sformatf("byte_count %0d, want %0d", cnt, want.byte_count));
      if (eot !== want.end_of_text)
        report($sformatf("end_of_text %b, want %b", eot, want.end_of_text));
    endtask
  endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// top of the utf-8 stream decoder testbench: stimulus, handshakes and verdict
module tb;
  import utf8d_pkg::*;
  import utf8_check_pkg::*;

  localparam int IdlePct      = 14;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 4;
  localparam int StallLimit   = 2000;

  typedef logic [7:0] byte_seq_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] out_code_point;
  logic [2:0]  out_status;
  logic [2:0]  out_byte_count;
  logic        out_end_of_text;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  utf8_scoreboard sb;

  // stimulus controls: no_gaps turns off idling on both sides, a change of
  // hold_req asks the receiver for one long hold-off
  logic no_gaps = 1'b0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   bytes_sent = 0;
  int   stall_cycles = 0;

  utf8_stream_decoder_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_byte_count (out_byte_count),
    .out_end_of_text(out_end_of_text),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // both channels are sampled in the active region of the edge, so every
  // value seen here is the one the block itself saw at that edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_byte(in_data_byte, in_last_byte);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_code_point, out_status, out_byte_count, out_end_of_text);
  end

  // watchdog: any stretch without a transfer on either channel that is far
  // longer than the receiver hold-off means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int HOLD_CYCLES_OR_ONE();
    return (HoldCycles > 0) ? HoldCycles : 1;
  endfunction

  // receiver: random backpressure, plus one long hold-off on request so the
  // output register fills and the block has to stall its byte input
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES_OR_ONE()) @(posedge clk);
      end
      out_ready <= no_gaps || ($urandom_range(99) >= IdlePct);
    end
  end

  // one byte transfer; random idle cycles go in front of it, valid then
  // stays high with a steady payload until the block takes the byte
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_gaps) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_seq(input byte_seq_t seq, input logic last_at_end);
    foreach (seq[i]) send_byte(seq[i], last_at_end && (i == seq.size() - 1));
  endtask

  // well-formed utf-8 of the given length; the code point bits are taken as
  // they are, so overlong forms come out too
  function automatic byte_seq_t utf8_encode(input logic [20:0] cp, input int len);
    byte_seq_t seq;
    case (len)
      1: seq = '{{1'b0, cp[6:0]}};
      2: seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
      3: seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      default: seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                       {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    endcase
    return seq;
  endfunction

  // mostly well-formed sequences with random content; the rest are cut
  // short, carry a broken continuation, start with 11111xxx, or are noise
  task automatic random_item();
    int         kind;
    int         len;
    int         cut;
    int         idx;
    logic [7:0] bad;
    logic       tail_last;
    byte_seq_t  seq;
    kind = $urandom_range(99);
    tail_last = ($urandom_range(11) == 0);
    if (kind < 68) begin
      len = $urandom_range(4, 1);
      send_seq(utf8_encode(21'($urandom), len), tail_last);
    end else if (kind < 78) begin
      // sequence cut short, by end of text or by whatever comes next
      len = $urandom_range(4, 2);
      seq = utf8_encode(21'($urandom), len);
      cut = $urandom_range(len - 1, 1);
      while (seq.size() > cut) void'(seq.pop_back());
      send_seq(seq, 1'($urandom_range(1)));
    end else if (kind < 86) begin
      // one continuation replaced by a byte that is not 10xxxxxx
      len = $urandom_range(4, 2);
      seq = utf8_encode(21'($urandom), len);
      idx = $urandom_range(len - 1, 1);
      bad = 8'($urandom);
      while (bad[7:6] == 2'b10) bad = 8'($urandom);
      seq[idx] = bad;
      send_seq(seq, tail_last);
    end else if (kind < 92) begin
      // 11111xxx lead followed by three continuations
      seq = '{{5'b11111, 3'($urandom)}, {2'b10, 6'($urandom)},
              {2'b10, 6'($urandom)}, {2'b10, 6'($urandom)}};
      send_seq(seq, tail_last);
    end else if (kind < 96) begin
      send_byte({2'b10, 6'($urandom)}, $urandom_range(3) == 0);
    end else begin
      send_byte(8'($urandom), $urandom_range(3) == 0);
    end
  endtask

  task automatic random_bytes(input int n);
    int target;
    target = bytes_sent + n;
    while (bytes_sent < target) random_item();
  endtask

  // a byte with last set always leaves the decoder idle; wait for the monitor
  // to note it, then for the last result and a settle time before touching
  // the register
  task automatic end_phase();
    send_byte(8'h0A, 1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_STRICT, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write strict_check, then read it back
  task automatic set_strict(input logic v);
    logic [31:0] rd;
    apb_xfer(1'b1, {31'd0, v}, rd);
    sb.strict_on = v;
    apb_xfer(1'b0, 32'd0, rd);
    if (rd[0] !== v) sb.report($sformatf("strict_check read %b, want %b", rd[0], v));
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // strict checks on (reset value): ascii extremes, stray continuation,
    // bad lead, 2- and 4-byte forms up to the top code point, bad
    // continuation, truncation, bad continuation on the final byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    end_phase();

    // strict checks off: 11111xxx taken as a 4-byte lead, any byte taken as
    // a continuation, truncation right at the lead, stray still reported
    set_strict(1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hC5, 1'b1);
    send_byte(8'h80, 1'b0);
    end_phase();

    // lenient random phase with one long receiver hold-off in the middle
    random_bytes(60);
    hold_req++;
    random_bytes(240);
    end_phase();

    // strict phase that opens with a stretch of back-to-back transfers
    set_strict(1'b1);
    no_gaps = 1'b1;
    random_bytes(160);
    no_gaps = 1'b0;
    random_bytes(170);
    end_phase();

    set_strict(1'b0);
    random_bytes(330);
    end_phase();

    set_strict(1'b1);
    random_bytes(330);
    end_phase();

    // a result still owed at the end is a lost result
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never came out", sb.outstanding()));

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
